// ===== rtl/vps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vps_pkg: shared types and constants for the Verlet particle step
// Item layouts, configuration register map and the screen-edge reflection math.
// ----------------------------------------------------------------------------
package vps_pkg;

  localparam int unsigned ADV_STAGES  = 6;
  localparam int unsigned REFL_STAGES = 2;
  localparam int unsigned PIPE_DEPTH  = ADV_STAGES + REFL_STAGES;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY   = 3'd0,
    CFG_DAMPING   = 3'd1,
    CFG_HALF_DT2  = 3'd2,
    CFG_SCREEN_W  = 3'd3,
    CFG_SCREEN_H  = 3'd4
  } cfg_idx_e;

  localparam logic [30:0] GRAVITY_RST  = 31'd25690112;
  localparam logic [15:0] DAMPING_RST  = 16'd655;
  localparam logic [31:0] HALF_DT2_RST = 32'd549756;
  localparam logic [15:0] SCREEN_W_RST = 16'd1024;
  localparam logic [15:0] SCREEN_H_RST = 16'd768;

  // 1.0 and 2.0 in Q16.16
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [31:0] TWO_Q16 = 32'sh0002_0000;

  typedef struct packed {
    logic [30:0] gravity_accel;
    logic [15:0] damping_ratio;
    logic [31:0] half_dt_squared;
    logic [15:0] screen_width;
    logic [15:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] prev_z;
    logic               is_pinned;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_z;
    logic signed [31:0] old_x;
    logic signed [31:0] old_y;
    logic signed [31:0] old_z;
  } out_item_t;

  // Fields that ride along the pipe untouched
  typedef struct packed {
    logic               pinned;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } side_t;

  // Below 1.0 -> mirror about 1.0
  function automatic logic signed [31:0] refl_low(input logic signed [31:0] x);
    logic signed [31:0] r;
    r = x;
    if (x < ONE_Q16) begin
      r = TWO_Q16 - x;
    end
    return r;
  endfunction

  // Above (size-1) -> mirror about (size-1); limit is exact in 34 bits
  function automatic logic signed [31:0] refl_high(input logic signed [31:0] x,
                                                   input logic [15:0]         size);
    logic signed [33:0] lim;
    logic signed [33:0] xw;
    logic signed [31:0] r;
    lim = $signed({2'b00, size, 16'h0000}) - 34'sd65536;
    xw  = $signed({{2{x[31]}}, x});
    r   = x;
    if (xw > lim) begin
      r = $signed({lim[30:0], 1'b0}) - x;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vps_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vps_stream_if: valid/ready stream channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface vps_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/verlet_particle_step_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// verlet_particle_step_top: damped Verlet step for one cloth particle
// Integrates three axes, reflects x/y off the screen edges, applies pinning.
// ----------------------------------------------------------------------------
//   channel | dir | transaction
//   in_i    | in  | pos, prev, pin flag, anchor of one particle
//   out_o   | out | next position and old position of that particle
//   cfg     | in  | register write, cfg_we_i high at the clock edge
//
// One particle per cycle while out_o is ready; the pipe has 6 integration
// stages and 2 reflection stages, set by the multiply chain v*d then a*h.
// Reset clears all stage valid bits and loads the default registers.
// Each stage holds only when it is full and the stage after it holds, so
// bubbles are squeezed out under back-pressure and nothing is dropped.
// ----------------------------------------------------------------------------
module verlet_particle_step_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  vps_stream_if.sink                         in_i,
  vps_stream_if.source                       out_o,
  input  wire                                cfg_we_i,
  input  wire  [vps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [vps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import vps_pkg::*;

  cfg_t                   cfg_q, cfg_d;
  logic [PIPE_DEPTH-1:0]  vld_q, vld_d;
  logic [PIPE_DEPTH-1:0]  en;
  side_t                  side_q [PIPE_DEPTH];
  logic signed [31:0]     adv_x, adv_y, adv_z;
  logic signed [31:0]     ref_x, ref_y, ref_z;

  // ---------------- configuration ----------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRAVITY:  cfg_d.gravity_accel   = cfg_data_i[30:0];
        CFG_DAMPING:  cfg_d.damping_ratio   = cfg_data_i[15:0];
        CFG_HALF_DT2: cfg_d.half_dt_squared = cfg_data_i[31:0];
        CFG_SCREEN_W: cfg_d.screen_width    = cfg_data_i[15:0];
        CFG_SCREEN_H: cfg_d.screen_height   = cfg_data_i[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_accel   <= GRAVITY_RST;
      cfg_q.damping_ratio   <= DAMPING_RST;
      cfg_q.half_dt_squared <= HALF_DT2_RST;
      cfg_q.screen_width    <= SCREEN_W_RST;
      cfg_q.screen_height   <= SCREEN_H_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- pipeline control ----------------
  always_comb begin
    en[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || out_o.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_i.valid;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready = en[0];

  // pass-through fields, one copy per stage
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0].pinned   <= in_i.data.is_pinned;
      side_q[0].anchor_x <= in_i.data.anchor_x;
      side_q[0].anchor_y <= in_i.data.anchor_y;
      side_q[0].anchor_z <= in_i.data.anchor_z;
      side_q[0].pos_x    <= in_i.data.pos_x;
      side_q[0].pos_y    <= in_i.data.pos_y;
      side_q[0].pos_z    <= in_i.data.pos_z;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------- datapath ----------------
  vps_advance u_adv_x (
    .clk_i      (clk_i),
    .en_i       (en[ADV_STAGES-1:0]),
    .pos_i      (in_i.data.pos_x),
    .prev_i     (in_i.data.prev_x),
    .grav_i     ('0),
    .damping_i  (cfg_q.damping_ratio),
    .half_dt2_i (cfg_q.half_dt_squared),
    .next_o     (adv_x)
  );

  vps_advance u_adv_y (
    .clk_i      (clk_i),
    .en_i       (en[ADV_STAGES-1:0]),
    .pos_i      (in_i.data.pos_y),
    .prev_i     (in_i.data.prev_y),
    .grav_i     (cfg_q.gravity_accel),
    .damping_i  (cfg_q.damping_ratio),
    .half_dt2_i (cfg_q.half_dt_squared),
    .next_o     (adv_y)
  );

  vps_advance u_adv_z (
    .clk_i      (clk_i),
    .en_i       (en[ADV_STAGES-1:0]),
    .pos_i      (in_i.data.pos_z),
    .prev_i     (in_i.data.prev_z),
    .grav_i     ('0),
    .damping_i  (cfg_q.damping_ratio),
    .half_dt2_i (cfg_q.half_dt_squared),
    .next_o     (adv_z)
  );

  vps_reflect u_reflect (
    .clk_i    (clk_i),
    .en_i     (en[PIPE_DEPTH-1:ADV_STAGES]),
    .nx_i     (adv_x),
    .ny_i     (adv_y),
    .nz_i     (adv_z),
    .width_i  (cfg_q.screen_width),
    .height_i (cfg_q.screen_height),
    .nx_o     (ref_x),
    .ny_o     (ref_y),
    .nz_o     (ref_z)
  );

  // ---------------- output ----------------
  assign out_o.valid       = vld_q[PIPE_DEPTH-1];
  assign out_o.data.next_x = side_q[PIPE_DEPTH-1].pinned ? side_q[PIPE_DEPTH-1].anchor_x : ref_x;
  assign out_o.data.next_y = side_q[PIPE_DEPTH-1].pinned ? side_q[PIPE_DEPTH-1].anchor_y : ref_y;
  assign out_o.data.next_z = side_q[PIPE_DEPTH-1].pinned ? side_q[PIPE_DEPTH-1].anchor_z : ref_z;
  assign out_o.data.old_x  = side_q[PIPE_DEPTH-1].pos_x;
  assign out_o.data.old_y  = side_q[PIPE_DEPTH-1].pos_y;
  assign out_o.data.old_z  = side_q[PIPE_DEPTH-1].pos_z;

  // ---------------- assertions ----------------
  // input only stalls when the whole pipe is full and the sink holds off
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready && (&vld_q)))
    else $error("input stalled with room in the pipe");

  // with the sink ready, a stage never holds its item
  a_flow_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.ready && vld_q[0]) |=> vld_q[1])
    else $error("item held in first stage while sink ready");

  // an accepted transaction reaches the output while the sink stays open
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) ##1 out_o.ready ##1 out_o.ready ##1 out_o.ready
      ##1 out_o.ready ##1 out_o.ready ##1 out_o.ready ##1 out_o.ready
      |=> out_o.valid)
    else $error("transaction did not reach the output in time");

  // a result that was not taken stays valid
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.data.old_x)))
    else $error("waiting result lost or changed");

endmodule
`default_nettype wire

// ===== rtl/vps_advance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vps_advance: per-axis damped Verlet integration, six register stages
// next = pos + v + round(a * half_dt^2), a = grav - round(v * damping).
// ----------------------------------------------------------------------------
module vps_advance (
  input  wire                              clk_i,
  input  wire  [vps_pkg::ADV_STAGES-1:0]   en_i,
  input  wire  signed [31:0]               pos_i,
  input  wire  signed [31:0]               prev_i,
  input  wire  [30:0]                      grav_i,
  input  wire  [15:0]                      damping_i,
  input  wire  [31:0]                      half_dt2_i,
  output logic signed [31:0]               next_o
);
  import vps_pkg::*;

  logic signed [32:0] v_q,    v_d;
  logic signed [31:0] pos_q;
  logic signed [49:0] prod_q, prod_d;
  logic signed [31:0] pv1_q, pv2_q, pv3_q, pv4_q;
  logic signed [31:0] pv_d;
  logic signed [34:0] a_q,    a_d;
  logic signed [51:0] p1_q,   p1_d;
  logic signed [51:0] p0_q,   p0_d;
  logic signed [31:0] disp_q, disp_d;
  logic signed [31:0] next_q, next_d;
  logic signed [49:0] damp_rnd;
  logic signed [52:0] disp_sum;

  always_comb begin
    v_d    = $signed({pos_i[31], pos_i}) - $signed({prev_i[31], prev_i});
    prod_d = v_q * $signed({1'b0, damping_i});
    pv_d   = pos_q + v_q[31:0];

    // round half up: floor((v*d + 0.5) / 2^16)
    damp_rnd = prod_q + 50'sd32768;
    a_d      = $signed({4'b0000, grav_i}) - $signed({damp_rnd[49], damp_rnd[49:16]});

    p1_d = a_q * $signed({1'b0, half_dt2_i[31:16]});
    p0_d = a_q * $signed({1'b0, half_dt2_i[15:0]});

    disp_sum = $signed({p1_q[51], p1_q}) + 53'sd32768
             + $signed({{17{p0_q[51]}}, p0_q[51:16]});
    disp_d   = disp_sum[47:16];

    next_d = pv4_q + disp_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v_q   <= v_d;
      pos_q <= pos_i;
    end
    if (en_i[1]) begin
      prod_q <= prod_d;
      pv1_q  <= pv_d;
    end
    if (en_i[2]) begin
      a_q   <= a_d;
      pv2_q <= pv1_q;
    end
    if (en_i[3]) begin
      p1_q  <= p1_d;
      p0_q  <= p0_d;
      pv3_q <= pv2_q;
    end
    if (en_i[4]) begin
      disp_q <= disp_d;
      pv4_q  <= pv3_q;
    end
    if (en_i[5]) begin
      next_q <= next_d;
    end
  end

  assign next_o = next_q;

endmodule
`default_nettype wire

// ===== rtl/vps_reflect.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vps_reflect: screen-edge reflection, two register stages
// Stage one: y low edge, x high edge. Stage two: y high edge, x low edge.
// ----------------------------------------------------------------------------
module vps_reflect (
  input  wire                              clk_i,
  input  wire  [vps_pkg::REFL_STAGES-1:0]  en_i,
  input  wire  signed [31:0]               nx_i,
  input  wire  signed [31:0]               ny_i,
  input  wire  signed [31:0]               nz_i,
  input  wire  [15:0]                      width_i,
  input  wire  [15:0]                      height_i,
  output logic signed [31:0]               nx_o,
  output logic signed [31:0]               ny_o,
  output logic signed [31:0]               nz_o
);
  import vps_pkg::*;

  logic signed [31:0] x1_q, y1_q, z1_q;
  logic signed [31:0] x2_q, y2_q, z2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      y1_q <= refl_low(ny_i);
      x1_q <= refl_high(nx_i, width_i);
      z1_q <= nz_i;
    end
    if (en_i[1]) begin
      y2_q <= refl_high(y1_q, height_i);
      x2_q <= refl_low(x1_q);
      z2_q <= z1_q;
    end
  end

  assign nx_o = x2_q;
  assign ny_o = y2_q;
  assign nz_o = z2_q;

endmodule
`default_nettype wire

// ===== bench/verlet_particle_step_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// verlet_particle_step_top_tb: self-checking bench for the Verlet particle step
// Drives particles through the stream channel with random gaps and back-pressure,
// predicts each next/old position in fixed point and checks every result.
// ----------------------------------------------------------------------------
module verlet_particle_step_top_tb;
  import vps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PRINT_CAP   = 40;
  localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN       = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst_n;

  vps_stream_if #(.T(in_item_t))  particle_if ();
  vps_stream_if #(.T(out_item_t)) result_if ();

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  verlet_particle_step_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (particle_if),
    .out_o      (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk = ~clk;

  // Register copy used by the predictor
  logic [30:0] gravity_q16;
  logic [15:0] damping_q16;
  logic [31:0] half_dt2_q32;
  logic [15:0] screen_w;
  logic [15:0] screen_h;

  out_item_t   expected_q[$];
  int unsigned mismatches;
  int unsigned particles_sent;
  int unsigned results_seen;
  int unsigned settings_used;
  int unsigned cycle_count;
  int          tx_max;
  int          rx_max;
  int          hold_len;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint wrap32(input longint x);
    logic signed [31:0] t;
    t = x[31:0];
    return t;
  endfunction

  function automatic logic signed [31:0] integrate_axis(input logic signed [31:0] pos,
                                                        input logic signed [31:0] prev,
                                                        input longint grav);
    longint vel, damp, acc, ratio, hdt_hi, hdt_lo, prod_hi, prod_lo, disp;
    logic [31:0] sum;
    ratio   = damping_q16;
    hdt_hi  = half_dt2_q32[31:16];
    hdt_lo  = half_dt2_q32[15:0];
    vel     = longint'(pos) - longint'(prev);
    // round half up on both products
    damp    = (vel * ratio + 64'sd32768) >>> 16;
    acc     = grav - damp;
    prod_hi = acc * hdt_hi + 64'sd32768;
    prod_lo = acc * hdt_lo;
    disp    = (prod_hi + (prod_lo >>> 16)) >>> 16;
    sum     = pos + vel[31:0] + disp[31:0];
    return sum;
  endfunction

  function automatic longint fold_low(input longint x);
    if (x < 64'sd65536) begin
      x = wrap32(64'sd131072 - x);
    end
    return x;
  endfunction

  // rim may be zero or negative for tiny screens; the test stays the same
  function automatic longint fold_high(input longint x, input logic [15:0] size);
    longint s, rim;
    s   = size;
    rim = (s - 1) * 64'sd65536;
    if (x > rim) begin
      x = wrap32(2 * rim - x);
    end
    return x;
  endfunction

  function automatic out_item_t predict_step(input in_item_t p);
    out_item_t r;
    longint    nx, ny, nz, g;
    g  = gravity_q16;
    nx = integrate_axis(p.pos_x, p.prev_x, 0);
    ny = integrate_axis(p.pos_y, p.prev_y, g);
    nz = integrate_axis(p.pos_z, p.prev_z, 0);
    ny = fold_low(ny);
    ny = fold_high(ny, screen_h);
    nx = fold_high(nx, screen_w);
    nx = fold_low(nx);
    if (p.is_pinned) begin
      r.next_x = p.anchor_x;
      r.next_y = p.anchor_y;
      r.next_z = p.anchor_z;
    end else begin
      r.next_x = nx[31:0];
      r.next_y = ny[31:0];
      r.next_z = nz[31:0];
    end
    r.old_x = p.pos_x;
    r.old_y = p.pos_y;
    r.old_z = p.pos_z;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int draw_wait(input int max_wait);
    if (max_wait == 0 || $urandom_range(1, 0) == 0) begin
      return 0;
    end
    return $urandom_range(max_wait, 0);
  endfunction

  function automatic logic [31:0] jitter(input int bits);
    int span;
    span = 1 << bits;
    return $urandom_range(span - 1, 0) - (span >> 1);
  endfunction

  function automatic logic [31:0] near_rim(input logic [15:0] size);
    if ($urandom_range(1, 0) == 0) begin
      return 32'h0001_0000 + jitter(18);
    end
    return {size - 16'd1, 16'h0000} + jitter(18);
  endfunction

  function automatic in_item_t particle(input logic [31:0] px, py, pz, qx, qy, qz,
                                       input logic pin,
                                       input logic [31:0] ax, ay, az);
    in_item_t p;
    p.pos_x    = px;
    p.pos_y    = py;
    p.pos_z    = pz;
    p.prev_x   = qx;
    p.prev_y   = qy;
    p.prev_z   = qz;
    p.is_pinned = pin;
    p.anchor_x = ax;
    p.anchor_y = ay;
    p.anchor_z = az;
    return p;
  endfunction

  function automatic in_item_t make_random_particle();
    in_item_t p;
    int       style;
    style = $urandom_range(9, 0);
    if (style <= 4) begin
      // on screen, modest speed
      p.pos_x  = $urandom_range({screen_w, 16'h0000}, 0);
      p.pos_y  = $urandom_range({screen_h, 16'h0000}, 0);
      p.pos_z  = jitter(24);
      p.prev_x = p.pos_x - jitter(20);
      p.prev_y = p.pos_y - jitter(20);
      p.prev_z = p.pos_z - jitter(20);
    end else if (style <= 6) begin
      // close to an edge, moving across it
      p.pos_x  = near_rim(screen_w);
      p.pos_y  = near_rim(screen_h);
      p.pos_z  = jitter(24);
      p.prev_x = p.pos_x - jitter(19);
      p.prev_y = p.pos_y - jitter(19);
      p.prev_z = p.pos_z - jitter(19);
    end else if (style == 7) begin
      p.pos_x  = $urandom;
      p.pos_y  = $urandom;
      p.pos_z  = $urandom;
      p.prev_x = p.pos_x - jitter(16);
      p.prev_y = p.pos_y - jitter(16);
      p.prev_z = p.pos_z - jitter(16);
    end else begin
      p.pos_x  = $urandom;
      p.pos_y  = $urandom;
      p.pos_z  = $urandom;
      p.prev_x = $urandom;
      p.prev_y = $urandom;
      p.prev_z = $urandom;
    end
    p.is_pinned = ($urandom_range(7, 0) == 0);
    p.anchor_x  = $urandom;
    p.anchor_y  = $urandom;
    p.anchor_z  = $urandom;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers (inputs change on the falling edge)
  // --------------------------------------------------------------------------
  task automatic send_particle(input in_item_t p);
    int gap;
    gap = draw_wait(tx_max);
    if (gap > 0) begin
      particle_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    particle_if.valid <= 1'b1;
    particle_if.data  <= p;
    do @(posedge clk); while (!particle_if.ready);
    expected_q.insert(expected_q.size(), predict_step(p));
    particles_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    particle_if.valid <= 1'b0;
    do @(negedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_GRAVITY:  gravity_q16  = val[30:0];
      CFG_DAMPING:  damping_q16  = val[15:0];
      CFG_HALF_DT2: half_dt2_q32 = val;
      CFG_SCREEN_W: screen_w     = val[15:0];
      CFG_SCREEN_H: screen_h     = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Only called with the pipe empty
  task automatic program_regs(input logic [31:0] grav, damp, hdt, w, h);
    write_reg(CFG_GRAVITY, grav);
    write_reg(CFG_DAMPING, damp);
    write_reg(CFG_HALF_DT2, hdt);
    write_reg(CFG_SCREEN_W, w);
    write_reg(CFG_SCREEN_H, h);
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int tx, input int rx);
    tx_max = tx;
    rx_max = rx;
    repeat (count) send_particle(make_random_particle());
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls plus an optional long hold
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    result_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        result_if.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      stall = draw_wait(rx_max);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid && hold_len == 0);
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want, got;
    if (rst_n === 1'b1 && result_if.valid && result_if.ready) begin
      results_seen++;
      got = result_if.data;
      if (expected_q.size() == 0) begin
        report_mismatch("transaction with nothing outstanding");
      end else begin
        want = expected_q.pop_front();
        if (got.next_x !== want.next_x)
          report_mismatch($sformatf("next_x exp %h got %h", want.next_x, got.next_x));
        if (got.next_y !== want.next_y)
          report_mismatch($sformatf("next_y exp %h got %h", want.next_y, got.next_y));
        if (got.next_z !== want.next_z)
          report_mismatch($sformatf("next_z exp %h got %h", want.next_z, got.next_z));
        if (got.old_x !== want.old_x)
          report_mismatch($sformatf("old_x exp %h got %h", want.old_x, got.old_x));
        if (got.old_y !== want.old_y)
          report_mismatch($sformatf("old_y exp %h got %h", want.old_y, got.old_y));
        if (got.old_z !== want.old_z)
          report_mismatch($sformatf("old_z exp %h got %h", want.old_z, got.old_z));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Registers at their reset values; covers rest, motion, pinning, wrap and
  // every edge reflection
  task automatic test_reset_defaults();
    tx_max = 3;
    rx_max = 3;
    send_particle(particle(32'h0200_0000, 32'h0180_0000, 0,
                           32'h0200_0000, 32'h0180_0000, 0, 1'b0, 0, 0, 0));
    send_particle(particle(32'h0064_8000, 32'h00C8_4000, 32'hFFFD_0000,
                           32'h0063_0000, 32'h00C9_0000, 32'hFFFD_8000, 1'b0, 0, 0, 0));
    send_particle(particle(32'h0010_0000, 32'h0020_0000, 32'h0030_0000,
                           32'h000F_0000, 32'h0021_0000, 32'h0030_0000, 1'b1,
                           32'h0007_0000, 32'h0008_0000, 32'h0009_0000));
    send_particle(particle(Q_MAX, Q_MIN, 0, Q_MIN, Q_MAX, 0, 1'b1, Q_MAX, Q_MIN, 0));
    send_particle(particle(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0,
                           $urandom, $urandom, $urandom));
    send_particle(particle(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0,
                           $urandom, $urandom, $urandom));
    send_particle(particle(0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0));
    send_particle(particle(32'h0001_0000, 32'h0001_0000, 0,
                           32'h0001_0000, 32'h0001_0000, 0, 1'b0, 0, 0, 0));
    send_particle(particle(32'h0000_FFFF, 32'h0000_FFFF, 0,
                           32'h0000_FFFF, 32'h0000_FFFF, 0, 1'b0, 0, 0, 0));
    send_particle(particle(32'h03FF_0000, 32'h02FF_0000, 0,
                           32'h03FF_0000, 32'h02FF_0000, 0, 1'b0, 0, 0, 0));
    send_particle(particle(32'h03FF_8000, 32'h02FF_8000, 0,
                           32'h03FE_0000, 32'h02FE_0000, 0, 1'b0, 0, 0, 0));
    send_particle(particle(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 0, 0, 0));
    send_particle(particle(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0, 0, 0));
    drain();
  endtask

  // All registers at their top values, then all at zero (screen size 0)
  task automatic test_register_extremes();
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_particle(particle(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0, 0, 0));
    send_particle(particle(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, 0, 0, 0));
    send_particle(particle(32'h1234_5678, 32'h0ABC_DEF0, 32'hF000_0001,
                           32'h1233_0000, 32'h0ABD_0000, 32'hF001_0000, 1'b0, 0, 0, 0));
    send_particle(particle(0, 0, 0, 0, 0, 0, 1'b1, Q_MIN, Q_MAX, 32'hFFFF_FFFF));
    drain();
    program_regs(0, 0, 0, 0, 0);
    send_particle(particle(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0, 0, 0));
    send_particle(particle(0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0));
    send_particle(particle(32'hFFFF_0000, 32'hFFFF_0000, 0,
                           32'hFFFE_0000, 32'hFFFF_8000, 0, 1'b0, 0, 0, 0));
    send_particle(particle(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0, 0, 0));
    drain();
  endtask

  task automatic test_random_sweeps();
    program_regs({1'b0, GRAVITY_RST}, {16'h0, DAMPING_RST}, HALF_DT2_RST,
                 {16'h0, SCREEN_W_RST}, {16'h0, SCREEN_H_RST});
    run_phase(200, 16, 16);
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
    run_phase(200, 4, 16);
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(180, 16, 4);
    program_regs(0, 0, 0, 0, 0);
    run_phase(180, 0, 0);
    program_regs($urandom, $urandom, $urandom, 2, 3);
    run_phase(180, 8, 8);
    program_regs($urandom, 32'h0000_FFFF, 32'hFFFF_FFFF, 1, 1);
    run_phase(180, 16, 0);
    program_regs($urandom, $urandom_range(4000, 0), $urandom_range(32'h0100_0000, 0),
                 $urandom_range(4096, 2), $urandom_range(4096, 2));
    run_phase(200, 2, 2);
  endtask

  // Output held off long enough that the pipe fills and stalls the input
  task automatic test_output_backpressure();
    tx_max   = 0;
    rx_max   = 0;
    hold_len = 64;
    repeat (48) send_particle(make_random_particle());
    drain();
  endtask

  initial begin
    particle_if.valid = 1'b0;
    particle_if.data  = '0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_GRAVITY;
    cfg_data          = '0;
    rst_n             = 1'b0;
    gravity_q16       = GRAVITY_RST;
    damping_q16       = DAMPING_RST;
    half_dt2_q32      = HALF_DT2_RST;
    screen_w          = SCREEN_W_RST;
    screen_h          = SCREEN_H_RST;
    mismatches        = 0;
    particles_sent    = 0;
    results_seen      = 0;
    settings_used     = 1;
    cycle_count       = 0;
    tx_max            = 0;
    rx_max            = 0;
    hold_len          = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_sweeps();
    test_output_backpressure();

    repeat (2 * PIPE_DEPTH) @(posedge clk);
    $display("Ran %0d particles under %0d register settings, %0d results checked",
             particles_sent, settings_used, results_seen);
    $display("Included reset values, register extremes, tiny screens and a long output hold");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
